/* rtl/psrs_pkg.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// psrs_pkg: shared types and constants for the partial sum rank/select table
// Operation codes, queue command kinds, sequencer states and fixed field
// widths used by the front end, the back end and the top level.
// ----------------------------------------------------------------------------
package psrs_pkg;

    // Fixed field widths of the stream payload
    localparam int ELEM_W   = 16;   // element_value
    localparam int OPND_W   = 24;   // query_operand, stored prefix sums
    localparam int ANS_W    = 25;   // answer
    localparam int SDATA_W  = 40;   // slave tdata, whole bytes
    localparam int MDATA_W  = 32;   // master tdata, whole bytes

    // Largest running total the table can hold
    localparam logic [OPND_W-1:0] TOTAL_LIMIT = {OPND_W{1'b1}};

    // Command queue between front and back end (depth is a power of two)
    localparam int QUEUE_DEPTH = 2;
    localparam int QPTR_W      = 1;

    // Request operation codes
    typedef enum logic [1:0] {
        OP_CLEAR  = 2'd0,
        OP_APPEND = 2'd1,
        OP_SUM    = 2'd2,
        OP_SEARCH = 2'd3
    } op_t;

    // Work kinds handed to the back end
    typedef enum logic [1:0] {
        KIND_REPLY  = 2'd0,   // answer zero, error flag as classified
        KIND_WRITE  = 2'd1,   // store a new prefix sum
        KIND_SUM    = 2'd2,   // read one prefix sum
        KIND_SEARCH = 2'd3    // binary search over the prefix sums
    } kind_t;

    // Control part of one queued command
    typedef struct packed {
        kind_t kind;
        logic  err;
    } cmd_ctl_t;

    // Back end sequencer states
    typedef enum logic [2:0] {
        ST_IDLE,
        ST_SUM_WAIT,
        ST_SRCH_STEP,
        ST_SRCH_WAIT,
        ST_EMIT
    } state_t;

endpackage

/* rtl/psrs_ram.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// psrs_ram: generic single-port-write, single-port-read RAM
// One write and one registered read per cycle; contents are not reset.
// ----------------------------------------------------------------------------
module psrs_ram #(
    parameter int WIDTH = 24,
    parameter int DEPTH = 256
) (
    input  logic                     clk,
    input  logic                     wr_en,
    input  logic [$clog2(DEPTH)-1:0] wr_addr,
    input  logic [WIDTH-1:0]         wr_data,
    input  logic                     rd_en,
    input  logic [$clog2(DEPTH)-1:0] rd_addr,
    output logic [WIDTH-1:0]         rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];

    // Write port
    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
    end

    // Registered read port
    always_ff @(posedge clk)
    begin
        if (rd_en)
        begin
            rd_data <= mem[rd_addr];
        end
    end

endmodule

/* rtl/psrs_front.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// psrs_front: request intake and classification
// Owns the element count and running total, range-checks each request,
// and pushes a command into a short queue that feeds the back end.
// ----------------------------------------------------------------------------
module psrs_front #(
    parameter int MAX_ELEMENTS = 256,
    parameter int VALUE_BITS   = 16
) (
    input  logic                                clk,
    input  logic                                rst_n,
    // request side
    input  logic                                s_tvalid,
    output logic                                s_tready,
    input  logic [psrs_pkg::SDATA_W-1:0]        s_tdata,
    input  logic [1:0]                          s_tuser,
    // command queue output
    output logic                                q_valid,
    input  logic                                q_ready,
    output psrs_pkg::cmd_ctl_t                  q_ctl,
    output logic [$clog2(MAX_ELEMENTS+1)-1:0]   q_idx,
    output logic [psrs_pkg::OPND_W-1:0]         q_data
);

    localparam int CNT_W = $clog2(MAX_ELEMENTS + 1);
    localparam logic [psrs_pkg::ELEM_W-1:0] VALUE_MASK =
        (VALUE_BITS >= psrs_pkg::ELEM_W) ? {psrs_pkg::ELEM_W{1'b1}} :
        psrs_pkg::ELEM_W'((32'd1 << VALUE_BITS) - 32'd1);

    // Table bookkeeping
    logic [CNT_W-1:0]            count_reg, count_next;
    logic [psrs_pkg::OPND_W-1:0] total_reg, total_next;

    // Command queue storage
    psrs_pkg::cmd_ctl_t          qctl_mem  [psrs_pkg::QUEUE_DEPTH];
    logic [CNT_W-1:0]            qidx_mem  [psrs_pkg::QUEUE_DEPTH];
    logic [psrs_pkg::OPND_W-1:0] qdata_mem [psrs_pkg::QUEUE_DEPTH];
    logic [psrs_pkg::QPTR_W-1:0] wr_ptr_reg, rd_ptr_reg;
    logic [psrs_pkg::QPTR_W:0]   fill_reg;

    // Classified command
    psrs_pkg::op_t               op;
    logic [psrs_pkg::ELEM_W-1:0] value;
    logic [psrs_pkg::OPND_W-1:0] operand;
    logic [psrs_pkg::OPND_W:0]   sum_ext;
    logic                        full;
    psrs_pkg::cmd_ctl_t          cmd_ctl;
    logic [CNT_W-1:0]            cmd_idx;
    logic [psrs_pkg::OPND_W-1:0] cmd_data;
    logic                        push, pop;

    // Unpack request fields
    assign op      = psrs_pkg::op_t'(s_tuser);
    assign value   = s_tdata[psrs_pkg::ELEM_W-1:0] & VALUE_MASK;
    assign operand = s_tdata[psrs_pkg::ELEM_W +: psrs_pkg::OPND_W];
    assign sum_ext = {1'b0, total_reg} + (psrs_pkg::OPND_W+1)'(value);
    assign full    = (count_reg == CNT_W'(MAX_ELEMENTS));

    assign s_tready = (fill_reg != (psrs_pkg::QPTR_W+1)'(psrs_pkg::QUEUE_DEPTH));
    assign push     = s_tvalid && s_tready;
    assign pop      = q_valid && q_ready;

    // Classify request and work out the new bookkeeping values
    always_comb
    begin
        cmd_ctl.kind = psrs_pkg::KIND_REPLY;
        cmd_ctl.err  = 1'b0;
        cmd_idx      = '0;
        cmd_data     = '0;
        count_next   = count_reg;
        total_next   = total_reg;
        unique case (op)
            psrs_pkg::OP_CLEAR:
            begin
                count_next = '0;
                total_next = '0;
            end
            psrs_pkg::OP_APPEND:
            begin
                if (full || sum_ext[psrs_pkg::OPND_W])
                begin
                    cmd_ctl.err = 1'b1;
                end
                else
                begin
                    cmd_ctl.kind = psrs_pkg::KIND_WRITE;
                    cmd_idx      = count_reg;
                    cmd_data     = sum_ext[psrs_pkg::OPND_W-1:0];
                    count_next   = count_reg + CNT_W'(1);
                    total_next   = sum_ext[psrs_pkg::OPND_W-1:0];
                end
            end
            psrs_pkg::OP_SUM:
            begin
                if (operand == '0 || operand > psrs_pkg::OPND_W'(count_reg))
                begin
                    cmd_ctl.err = 1'b1;
                end
                else
                begin
                    cmd_ctl.kind = psrs_pkg::KIND_SUM;
                    cmd_idx      = CNT_W'(operand - psrs_pkg::OPND_W'(1));
                end
            end
            psrs_pkg::OP_SEARCH:
            begin
                if (operand == '0 || operand > total_reg)
                begin
                    cmd_ctl.err = 1'b1;
                end
                else
                begin
                    cmd_ctl.kind = psrs_pkg::KIND_SEARCH;
                    cmd_idx      = count_reg;
                    cmd_data     = operand;
                end
            end
            default:
            begin
                cmd_ctl.err = 1'b1;
            end
        endcase
    end

    // Advance bookkeeping on each accepted request
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg <= '0;
            total_reg <= '0;
        end
        else if (push)
        begin
            count_reg <= count_next;
            total_reg <= total_next;
        end
    end

    // Queue payload write
    always_ff @(posedge clk)
    begin
        if (push)
        begin
            qctl_mem[wr_ptr_reg]  <= cmd_ctl;
            qidx_mem[wr_ptr_reg]  <= cmd_idx;
            qdata_mem[wr_ptr_reg] <= cmd_data;
        end
    end

    // Queue pointers and fill level
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            fill_reg   <= '0;
        end
        else
        begin
            if (push)
            begin
                wr_ptr_reg <= wr_ptr_reg + psrs_pkg::QPTR_W'(1);
            end
            if (pop)
            begin
                rd_ptr_reg <= rd_ptr_reg + psrs_pkg::QPTR_W'(1);
            end
            if (push && !pop)
            begin
                fill_reg <= fill_reg + (psrs_pkg::QPTR_W+1)'(1);
            end
            else if (pop && !push)
            begin
                fill_reg <= fill_reg - (psrs_pkg::QPTR_W+1)'(1);
            end
        end
    end

    // Queue head
    assign q_valid = (fill_reg != '0);
    assign q_ctl   = qctl_mem[rd_ptr_reg];
    assign q_idx   = qidx_mem[rd_ptr_reg];
    assign q_data  = qdata_mem[rd_ptr_reg];

endmodule

/* rtl/psrs_back.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// psrs_back: command execution
// Writes and reads the prefix sum memory, runs the binary search one probe
// at a time, and holds each answer in an output register.
// ----------------------------------------------------------------------------
module psrs_back #(
    parameter int MAX_ELEMENTS = 256
) (
    input  logic                                clk,
    input  logic                                rst_n,
    // command queue input
    input  logic                                q_valid,
    output logic                                q_ready,
    input  psrs_pkg::cmd_ctl_t                  q_ctl,
    input  logic [$clog2(MAX_ELEMENTS+1)-1:0]   q_idx,
    input  logic [psrs_pkg::OPND_W-1:0]         q_data,
    // prefix sum memory
    output logic                                ram_wr_en,
    output logic [$clog2(MAX_ELEMENTS)-1:0]     ram_wr_addr,
    output logic [psrs_pkg::OPND_W-1:0]         ram_wr_data,
    output logic                                ram_rd_en,
    output logic [$clog2(MAX_ELEMENTS)-1:0]     ram_rd_addr,
    input  logic [psrs_pkg::OPND_W-1:0]         ram_rd_data,
    // result side
    output logic                                res_valid,
    input  logic                                res_ready,
    output logic [psrs_pkg::ANS_W-1:0]          res_answer,
    output logic                                res_error
);

    localparam int ADDR_W = $clog2(MAX_ELEMENTS);
    localparam int CNT_W  = $clog2(MAX_ELEMENTS + 1);

    psrs_pkg::state_t             state_reg, state_next;
    logic [CNT_W-1:0]             lo_reg, lo_next;
    logic [CNT_W-1:0]             hi_reg, hi_next;
    logic [CNT_W-1:0]             mid_reg, mid_next;
    logic [psrs_pkg::OPND_W-1:0]  key_reg, key_next;
    logic [psrs_pkg::ANS_W-1:0]   pend_answer_reg, pend_answer_next;
    logic                         pend_error_reg, pend_error_next;
    logic                         out_valid_reg, out_valid_next;
    logic [psrs_pkg::ANS_W-1:0]   out_answer_reg, out_answer_next;
    logic                         out_error_reg, out_error_next;

    logic [CNT_W-1:0]             mid_calc;
    logic                         range_open;
    logic                         out_free;

    assign mid_calc   = lo_reg + ((hi_reg - lo_reg) >> 1);
    assign range_open = (lo_reg < hi_reg);
    assign out_free   = !out_valid_reg || res_ready;

    // Next state
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            psrs_pkg::ST_IDLE:
            begin
                if (q_valid)
                begin
                    unique case (q_ctl.kind)
                        psrs_pkg::KIND_SUM:    state_next = psrs_pkg::ST_SUM_WAIT;
                        psrs_pkg::KIND_SEARCH: state_next = psrs_pkg::ST_SRCH_STEP;
                        default:               state_next = psrs_pkg::ST_EMIT;
                    endcase
                end
            end
            psrs_pkg::ST_SUM_WAIT:
            begin
                state_next = psrs_pkg::ST_EMIT;
            end
            psrs_pkg::ST_SRCH_STEP:
            begin
                state_next = range_open ? psrs_pkg::ST_SRCH_WAIT : psrs_pkg::ST_EMIT;
            end
            psrs_pkg::ST_SRCH_WAIT:
            begin
                state_next = psrs_pkg::ST_SRCH_STEP;
            end
            psrs_pkg::ST_EMIT:
            begin
                if (out_free)
                begin
                    state_next = psrs_pkg::ST_IDLE;
                end
            end
            default:
            begin
                state_next = psrs_pkg::ST_IDLE;
            end
        endcase
    end

    // Queue pop and memory port controls
    always_comb
    begin
        q_ready     = 1'b0;
        ram_wr_en   = 1'b0;
        ram_wr_addr = q_idx[ADDR_W-1:0];
        ram_wr_data = q_data;
        ram_rd_en   = 1'b0;
        ram_rd_addr = q_idx[ADDR_W-1:0];
        unique case (state_reg)
            psrs_pkg::ST_IDLE:
            begin
                q_ready   = 1'b1;
                ram_wr_en = q_valid && (q_ctl.kind == psrs_pkg::KIND_WRITE);
                ram_rd_en = q_valid && (q_ctl.kind == psrs_pkg::KIND_SUM);
            end
            psrs_pkg::ST_SRCH_STEP:
            begin
                ram_rd_en   = range_open;
                ram_rd_addr = mid_calc[ADDR_W-1:0];
            end
            default:
            begin
                q_ready = 1'b0;
            end
        endcase
    end

    // Search bounds and pending answer
    always_comb
    begin
        lo_next          = lo_reg;
        hi_next          = hi_reg;
        mid_next         = mid_reg;
        key_next         = key_reg;
        pend_answer_next = pend_answer_reg;
        pend_error_next  = pend_error_reg;
        unique case (state_reg)
            psrs_pkg::ST_IDLE:
            begin
                if (q_valid)
                begin
                    lo_next          = '0;
                    hi_next          = q_idx;
                    key_next         = q_data;
                    pend_answer_next = '0;
                    pend_error_next  = q_ctl.err;
                end
            end
            psrs_pkg::ST_SUM_WAIT:
            begin
                pend_answer_next = psrs_pkg::ANS_W'(ram_rd_data) + psrs_pkg::ANS_W'(1);
            end
            psrs_pkg::ST_SRCH_STEP:
            begin
                mid_next         = mid_calc;
                pend_answer_next = psrs_pkg::ANS_W'(lo_reg);
            end
            psrs_pkg::ST_SRCH_WAIT:
            begin
                // Drop the lower half when the probe is still below the key
                if (ram_rd_data < key_reg)
                begin
                    lo_next = mid_reg + CNT_W'(1);
                end
                else
                begin
                    hi_next = mid_reg;
                end
            end
            default:
            begin
                pend_error_next = pend_error_reg;
            end
        endcase
    end

    // Output register: load on emit, clear when taken
    always_comb
    begin
        out_answer_next = out_answer_reg;
        out_error_next  = out_error_reg;
        out_valid_next  = out_valid_reg && !res_ready;
        if (state_reg == psrs_pkg::ST_EMIT && out_free)
        begin
            out_valid_next  = 1'b1;
            out_answer_next = pend_answer_reg;
            out_error_next  = pend_error_reg;
        end
    end

    // Control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= psrs_pkg::ST_IDLE;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // Payload registers
    always_ff @(posedge clk)
    begin
        lo_reg          <= lo_next;
        hi_reg          <= hi_next;
        mid_reg         <= mid_next;
        key_reg         <= key_next;
        pend_answer_reg <= pend_answer_next;
        pend_error_reg  <= pend_error_next;
        out_answer_reg  <= out_answer_next;
        out_error_reg   <= out_error_next;
    end

    assign res_valid  = out_valid_reg;
    assign res_answer = out_answer_reg;
    assign res_error  = out_error_reg;

endmodule

/* rtl/partial_sum_rank_select_table.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// partial_sum_rank_select_table: prefix sum table with rank/select queries
//
// Requests enter on the s_ channel: s_tuser carries the operation (clear,
// append, sum query, search query), s_tdata the element value and the query
// operand. Every request gives exactly one response on the m_ channel:
// m_tdata carries the answer, m_tuser the error flag.
// A front end checks each request against the element count and running
// total and queues a command; a back end executes it against the prefix
// sum memory (one registered read port) and holds the answer in an output
// register. A search query makes P memory probes (at most ceil(log2(count+1)))
// that each take a read and a compare. The back end works on one command at a
// time; the front end keeps taking requests while its two-entry queue has room.
// Reset empties the table and the queue; memory contents are not cleared.
// While m_tready is low the response stays in the output register and the
// back end, then the queue, then s_tready back up in turn.
// ----------------------------------------------------------------------------
module partial_sum_rank_select_table #(
    parameter int MAX_ELEMENTS = 256,
    parameter int VALUE_BITS   = 16
) (
    input  logic                          clk,
    input  logic                          rst_n,
    // request channel
    input  logic                          s_tvalid,
    output logic                          s_tready,
    input  logic [psrs_pkg::SDATA_W-1:0]  s_tdata,   // element_value[15:0], query_operand[39:16]
    input  logic [1:0]                    s_tuser,   // operation[1:0]
    // response channel
    output logic                          m_tvalid,
    input  logic                          m_tready,
    output logic [psrs_pkg::MDATA_W-1:0]  m_tdata,   // answer[24:0], zero fill[31:25]
    output logic [0:0]                    m_tuser    // error[0]
);

    localparam int ADDR_W = $clog2(MAX_ELEMENTS);
    localparam int CNT_W  = $clog2(MAX_ELEMENTS + 1);

    logic                         q_valid, q_ready;
    psrs_pkg::cmd_ctl_t           q_ctl;
    logic [CNT_W-1:0]             q_idx;
    logic [psrs_pkg::OPND_W-1:0]  q_data;

    logic                         ram_wr_en, ram_rd_en;
    logic [ADDR_W-1:0]            ram_wr_addr, ram_rd_addr;
    logic [psrs_pkg::OPND_W-1:0]  ram_wr_data, ram_rd_data;

    logic [psrs_pkg::ANS_W-1:0]   res_answer;
    logic                         res_error;

    // Intake and classification
    psrs_front #(
        .MAX_ELEMENTS (MAX_ELEMENTS),
        .VALUE_BITS   (VALUE_BITS)
    ) u_front (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .q_valid  (q_valid),
        .q_ready  (q_ready),
        .q_ctl    (q_ctl),
        .q_idx    (q_idx),
        .q_data   (q_data)
    );

    // Execution
    psrs_back #(
        .MAX_ELEMENTS (MAX_ELEMENTS)
    ) u_back (
        .clk         (clk),
        .rst_n       (rst_n),
        .q_valid     (q_valid),
        .q_ready     (q_ready),
        .q_ctl       (q_ctl),
        .q_idx       (q_idx),
        .q_data      (q_data),
        .ram_wr_en   (ram_wr_en),
        .ram_wr_addr (ram_wr_addr),
        .ram_wr_data (ram_wr_data),
        .ram_rd_en   (ram_rd_en),
        .ram_rd_addr (ram_rd_addr),
        .ram_rd_data (ram_rd_data),
        .res_valid   (m_tvalid),
        .res_ready   (m_tready),
        .res_answer  (res_answer),
        .res_error   (res_error)
    );

    // Prefix sum memory
    psrs_ram #(
        .WIDTH (psrs_pkg::OPND_W),
        .DEPTH (MAX_ELEMENTS)
    ) u_prefix_ram (
        .clk     (clk),
        .wr_en   (ram_wr_en),
        .wr_addr (ram_wr_addr),
        .wr_data (ram_wr_data),
        .rd_en   (ram_rd_en),
        .rd_addr (ram_rd_addr),
        .rd_data (ram_rd_data)
    );

    // Pack response
    assign m_tdata    = {{(psrs_pkg::MDATA_W - psrs_pkg::ANS_W){1'b0}}, res_answer};
    assign m_tuser[0] = res_error;

endmodule
